[hw/rtl/spcs_pkg.sv]
package spcs_pkg;

   // fixed field widths and counts
   localparam int NUM_CLASSES = 4;
   localparam int CLASS_BITS  = 2;
   localparam int TICK_BITS   = 32;

   // item kinds carried in the mode field
   localparam logic MODE_ARRIVAL = 1'b0;
   localparam logic MODE_TICK    = 1'b1;

   // controller states
   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic accept_arrival;
      logic accept_tick;
      logic answer;
      logic load_result;
      logic rsp_pop;
   } dp_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic tick_needs_read;
      logic rsp_valid;
   } dp_status_type;

endpackage

[hw/rtl/spcs_if.sv]
interface spcs_req_if #(
   parameter int ID_BITS       = 10,
   parameter int DURATION_BITS = 16
);
   import spcs_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     mode;
   logic [CLASS_BITS-1:0]    caller_class;
   logic [ID_BITS-1:0]       caller_id;
   logic [DURATION_BITS-1:0] call_duration;

   modport source (
      output valid, mode, caller_class, caller_id, call_duration,
      input  ready
   );

   modport sink (
      input  valid, mode, caller_class, caller_id, call_duration,
      output ready
   );
endinterface

interface spcs_rsp_if #(
   parameter int ID_BITS = 10
);
   import spcs_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  answered;
   logic [ID_BITS-1:0]    answered_id;
   logic [CLASS_BITS-1:0] answered_class;
   logic                  dropped;
   logic                  server_busy;
   logic [TICK_BITS-1:0]  tick_number;

   modport source (
      output valid, answered, answered_id, answered_class, dropped, server_busy,
             tick_number,
      input  ready
   );

   modport sink (
      input  valid, answered, answered_id, answered_class, dropped, server_busy,
             tick_number,
      output ready
   );
endinterface

[hw/rtl/spcs_ctrl.sv]
module spcs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_mode,
   output logic                   req_ready,
   input  logic                   rsp_ready,
   input  spcs_pkg::dp_status_type status,
   output spcs_pkg::dp_cmd_type    cmd
);
   import spcs_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   // take an item only when idle and the result slot is free by the next edge
   assign req_ready = (state_ff == ST_IDLE) && (!status.rsp_valid || rsp_ready);
   assign accept    = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_mode == MODE_TICK) && status.tick_needs_read) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath commands
   always_comb begin
      cmd             = '0;
      cmd.rsp_pop     = status.rsp_valid && rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept_arrival = accept && (req_mode == MODE_ARRIVAL);
            cmd.accept_tick    = accept && (req_mode == MODE_TICK);
            cmd.load_result    = cmd.accept_arrival ||
                                 (cmd.accept_tick && !status.tick_needs_read);
         end
         ST_READ: begin
            cmd.answer      = 1'b1;
            cmd.load_result = 1'b1;
         end
         default: begin
            cmd.load_result = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hw/rtl/spcs_dpath.sv]
module spcs_dpath #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int ID_BITS       = 10,
   parameter int DURATION_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  spcs_pkg::dp_cmd_type             cmd,
   output spcs_pkg::dp_status_type          status,
   input  logic [spcs_pkg::CLASS_BITS-1:0]  req_caller_class,
   input  logic [ID_BITS-1:0]               req_caller_id,
   input  logic [DURATION_BITS-1:0]         req_call_duration,
   output logic                            rsp_valid,
   output logic                            rsp_answered,
   output logic [ID_BITS-1:0]               rsp_answered_id,
   output logic [spcs_pkg::CLASS_BITS-1:0]  rsp_answered_class,
   output logic                            rsp_dropped,
   output logic                            rsp_server_busy,
   output logic [spcs_pkg::TICK_BITS-1:0]   rsp_tick_number
);
   import spcs_pkg::*;

   localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_BITS  = CLASS_BITS + PTR_BITS;
   localparam int MEM_DEPTH  = NUM_CLASSES << PTR_BITS;
   localparam int ENTRY_BITS = ID_BITS + DURATION_BITS;

   // queue bookkeeping
   logic [PTR_BITS-1:0] head_ff  [NUM_CLASSES];
   logic [PTR_BITS-1:0] head_in  [NUM_CLASSES];
   logic [PTR_BITS-1:0] tail_ff  [NUM_CLASSES];
   logic [PTR_BITS-1:0] tail_in  [NUM_CLASSES];
   logic [CNT_BITS-1:0] count_ff [NUM_CLASSES];
   logic [CNT_BITS-1:0] count_in [NUM_CLASSES];

   logic [DURATION_BITS-1:0] busy_ff;
   logic [DURATION_BITS-1:0] busy_in;
   logic [TICK_BITS-1:0]     tick_ff;
   logic [TICK_BITS-1:0]     tick_in;
   logic [CLASS_BITS-1:0]    pend_class_ff;

   // entry memory
   logic [ENTRY_BITS-1:0] mem [MEM_DEPTH];
   logic [ENTRY_BITS-1:0] rd_data_ff;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic                  wr_en;

   // result register
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic                  out_answered_ff;
   logic [ID_BITS-1:0]    out_id_ff;
   logic [CLASS_BITS-1:0] out_class_ff;
   logic                  out_dropped_ff;
   logic                  out_busy_ff;
   logic [TICK_BITS-1:0]  out_tick_ff;

   logic                  pick_any;
   logic [CLASS_BITS-1:0] pick_class;
   logic                  queue_full;
   logic                  server_busy;
   logic [ID_BITS-1:0]       rd_id;
   logic [DURATION_BITS-1:0] rd_dur;

   // highest non-empty class
   always_comb begin
      pick_any   = 1'b0;
      pick_class = '0;
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if (count_ff[c] != '0) begin
            pick_any   = 1'b1;
            pick_class = CLASS_BITS'(c);
         end
      end
   end

   assign server_busy = (busy_ff != '0);
   assign queue_full  = (count_ff[req_caller_class] == CNT_BITS'(QUEUE_DEPTH));
   assign wr_en       = cmd.accept_arrival && !queue_full;
   assign wr_addr     = {req_caller_class, tail_ff[req_caller_class]};
   assign rd_addr     = {pick_class, head_ff[pick_class]};
   assign {rd_id, rd_dur} = rd_data_ff;

   assign status = '{tick_needs_read: pick_any && !server_busy, rsp_valid: out_valid_ff};

   // pointer and count updates
   always_comb begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
         head_in[c]  = head_ff[c];
         tail_in[c]  = tail_ff[c];
         count_in[c] = count_ff[c];
      end
      if (wr_en) begin
         tail_in[req_caller_class] =
            (tail_ff[req_caller_class] == PTR_BITS'(QUEUE_DEPTH - 1)) ?
            '0 : tail_ff[req_caller_class] + PTR_BITS'(1);
         count_in[req_caller_class] = count_ff[req_caller_class] + CNT_BITS'(1);
      end
      if (cmd.accept_tick && status.tick_needs_read) begin
         head_in[pick_class] =
            (head_ff[pick_class] == PTR_BITS'(QUEUE_DEPTH - 1)) ?
            '0 : head_ff[pick_class] + PTR_BITS'(1);
         count_in[pick_class] = count_ff[pick_class] - CNT_BITS'(1);
      end
   end

   // busy counter and tick counter
   always_comb begin
      busy_in = busy_ff;
      tick_in = tick_ff;
      if (cmd.accept_tick) begin
         if (server_busy) begin
            busy_in = busy_ff - DURATION_BITS'(1);
         end
         if (!status.tick_needs_read) begin
            tick_in = tick_ff + TICK_BITS'(1);
         end
      end
      if (cmd.answer) begin
         busy_in = (rd_dur == '0) ? '0 : rd_dur - DURATION_BITS'(1);
         tick_in = tick_ff + TICK_BITS'(1);
      end
   end

   // result slot valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (cmd.load_result) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            head_ff[c]  <= '0;
            tail_ff[c]  <= '0;
            count_ff[c] <= '0;
         end
         busy_ff      <= '0;
         tick_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            head_ff[c]  <= head_in[c];
            tail_ff[c]  <= tail_in[c];
            count_ff[c] <= count_in[c];
         end
         busy_ff      <= busy_in;
         tick_ff      <= tick_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // entry memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {req_caller_id, req_call_duration};
      end
      rd_data_ff <= mem[rd_addr];
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.accept_tick) begin
         pend_class_ff <= pick_class;
      end
      if (cmd.answer) begin
         out_answered_ff <= 1'b1;
         out_id_ff       <= rd_id;
         out_class_ff    <= pend_class_ff;
         out_dropped_ff  <= 1'b0;
         out_busy_ff     <= 1'b0;
         out_tick_ff     <= tick_ff;
      end else if (cmd.load_result) begin
         out_answered_ff <= 1'b0;
         out_id_ff       <= '0;
         out_class_ff    <= '0;
         out_dropped_ff  <= cmd.accept_arrival && queue_full;
         out_busy_ff     <= cmd.accept_tick && server_busy;
         out_tick_ff     <= tick_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_answered       = out_answered_ff;
   assign rsp_answered_id    = out_id_ff;
   assign rsp_answered_class = out_class_ff;
   assign rsp_dropped        = out_dropped_ff;
   assign rsp_server_busy    = out_busy_ff;
   assign rsp_tick_number    = out_tick_ff;

endmodule

[hw/rtl/strict_priority_call_scheduler_unit.sv]
// Strict-priority call scheduler: one server in front of four FIFO queues, class 0 highest.
// An arrival item (mode 0) queues its id and duration in its class queue, or is flagged
// dropped when that queue already holds QUEUE_DEPTH entries. A tick item (mode 1) reports
// the server busy while a call is in service; otherwise it answers the oldest call of the
// highest non-empty class, which then keeps the server busy through duration-1 further
// ticks (duration 0 acts as 1). Every item gives exactly one result, and tick_number is the
// index of the current tick (for an arrival, of the next tick), wrapping at 2^32. An arrival,
// and a tick that answers nothing, load their result on acceptance; a tick that answers a call
// passes through a read state first, because the queued entry comes out of the entry memory
// through its registered read port. The result sits in an output register, so in the idle
// state the next item is taken while it waits as long as the result channel drains it in the same cycle.
module strict_priority_call_scheduler_unit #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int ID_BITS       = 10,
   parameter int DURATION_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   spcs_req_if.sink   req_ch,
   spcs_rsp_if.source rsp_ch
);
   import spcs_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // controller
   spcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_mode  (req_ch.mode),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // queues, counters and result register
   spcs_dpath #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .ID_BITS       (ID_BITS),
      .DURATION_BITS (DURATION_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_caller_class   (req_ch.caller_class),
      .req_caller_id      (req_ch.caller_id),
      .req_call_duration  (req_ch.call_duration),
      .rsp_valid          (rsp_ch.valid),
      .rsp_answered       (rsp_ch.answered),
      .rsp_answered_id    (rsp_ch.answered_id),
      .rsp_answered_class (rsp_ch.answered_class),
      .rsp_dropped        (rsp_ch.dropped),
      .rsp_server_busy    (rsp_ch.server_busy),
      .rsp_tick_number    (rsp_ch.tick_number)
   );

endmodule
